FILE: hw/rtl/trps_pkg.sv
// ----------------------------------------------------------------------------
// Timed relay phase sequencer package
// Widths, phase codes and register indexes shared by the sequencer files.
// ----------------------------------------------------------------------------
package trps_pkg;

	localparam int COUNT_BITS   = 16;
	localparam int CFG_BITS     = 16;
	localparam int CMP_BITS     = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
	localparam int LEVEL_BITS   = 8;
	localparam int PHASE_BITS   = 2;
	localparam int PULSE_BITS   = 16;
	localparam int OUT_CNT_BITS = 16;
	localparam int CFG_IDX_BITS = 3;

	localparam logic [PHASE_BITS-1:0] PH_START = 2'd0;
	localparam logic [PHASE_BITS-1:0] PH_RUN   = 2'd1;
	localparam logic [PHASE_BITS-1:0] PH_PULSE = 2'd2;
	localparam logic [PHASE_BITS-1:0] PH_FREE  = 2'd3;

	localparam logic [CFG_IDX_BITS-1:0] REG_RUN_SECONDS   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_CYCLE_SECONDS = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_FREE_SECONDS  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_PULSE_ON_MS   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_PULSE_OFF_MS  = 3'd4;

	localparam logic [CFG_BITS-1:0] RST_RUN_SECONDS   = 16'd10;
	localparam logic [CFG_BITS-1:0] RST_CYCLE_SECONDS = 16'd60;
	localparam logic [CFG_BITS-1:0] RST_FREE_SECONDS  = 16'd30;
	localparam logic [CFG_BITS-1:0] RST_PULSE_ON_MS   = 16'd8000;
	localparam logic [CFG_BITS-1:0] RST_PULSE_OFF_MS  = 16'd2000;

	typedef struct packed {
		logic                    relay_feed;
		logic                    relay_release;
		logic                    relay_ultrasonic;
		logic [PHASE_BITS-1:0]   phase;
		logic [OUT_CNT_BITS-1:0] elapsed_seconds;
		logic                    pwm_load;
		logic [LEVEL_BITS-1:0]   pwm_compare;
	} trps_result_t;

endpackage

FILE: hw/rtl/trps_if.sv
// ----------------------------------------------------------------------------
// Timed relay phase sequencer channels
// Tick input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface trps_in_if;
	logic                           valid;
	logic                           ready;
	logic                           second_edge;
	logic                           power_on;
	logic [trps_pkg::LEVEL_BITS-1:0] level;

	modport source (output valid, second_edge, power_on, level, input ready);
	modport sink   (input valid, second_edge, power_on, level, output ready);
endinterface

interface trps_out_if;
	logic                             valid;
	logic                             ready;
	logic                             relay_feed;
	logic                             relay_release;
	logic                             relay_ultrasonic;
	logic [trps_pkg::PHASE_BITS-1:0]   phase;
	logic [trps_pkg::OUT_CNT_BITS-1:0] elapsed_seconds;
	logic                             pwm_load;
	logic [trps_pkg::LEVEL_BITS-1:0]   pwm_compare;

	modport source (output valid, relay_feed, relay_release, relay_ultrasonic, phase,
		elapsed_seconds, pwm_load, pwm_compare, input ready);
	modport sink   (input valid, relay_feed, relay_release, relay_ultrasonic, phase,
		elapsed_seconds, pwm_load, pwm_compare, output ready);
endinterface

interface trps_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [trps_pkg::CFG_IDX_BITS-1:0] index;
	logic [trps_pkg::CFG_BITS-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/timed_relay_phase_sequencer.sv
// ----------------------------------------------------------------------------
// Timed relay phase sequencer
// Four-phase feed, ultrasonic pulse and release relay sequencer, one tick
// transaction per millisecond.
// ----------------------------------------------------------------------------
//  Channel | Dir | Payload                                      | Accepted when
//  din     | in  | second_edge, power_on, level                 | valid && ready
//  dout    | out | relays, phase, elapsed_seconds, pwm load/cmp | valid && ready
//  cfg     | in  | index, data                                  | valid && ready
//
//  A tick is captured in the input register and then processed into the
//  result register, which drives dout.valid; one tick per cycle while dout
//  is not stalled.
//  The input register advances into the result register whenever that
//  register is empty or being drained, so din.ready stays high while a
//  result waits unless both registers are full.
//  Reset restores the register defaults and clears all sequencer state.
//  cfg.ready is always high.
// ----------------------------------------------------------------------------
module timed_relay_phase_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	trps_in_if.sink    din,
	trps_out_if.source dout,
	trps_cfg_if.sink   cfg
);
	import trps_pkg::*;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [PULSE_BITS-1:0] PMS_MAX = {PULSE_BITS{1'b1}};

	// Configuration registers.
	logic [CFG_BITS-1:0] run_seconds_q, cycle_seconds_q, free_seconds_q;
	logic [CFG_BITS-1:0] pulse_on_ms_q, pulse_off_ms_q;

	// Input register.
	logic                  in_valid_s1;
	logic                  second_edge_s1;
	logic                  power_on_s1;
	logic [LEVEL_BITS-1:0] level_s1;

	// Sequencer state.
	logic [PHASE_BITS-1:0] phase_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  pulse_active_q;
	logic [PULSE_BITS-1:0] pulse_ms_q;
	logic                  feed_q, release_q, ultra_q;
	logic [LEVEL_BITS-1:0] last_level_q;

	// Result register.
	logic         out_valid_q;
	trps_result_t res_q;

	// Next-state values.
	logic [PHASE_BITS-1:0] ph_n;
	logic [COUNT_BITS-1:0] cnt_n;
	logic                  pa_n;
	logic [PULSE_BITS-1:0] pms_n;
	logic                  feed_n, rel_n, ult_n;
	logic [CMP_BITS-1:0]   cnt_w;
	trps_result_t          res_n;

	logic advance;

	assign advance   = in_valid_s1 && (!out_valid_q || dout.ready);
	assign din.ready = !in_valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_seconds_q   <= RST_RUN_SECONDS;
			cycle_seconds_q <= RST_CYCLE_SECONDS;
			free_seconds_q  <= RST_FREE_SECONDS;
			pulse_on_ms_q   <= RST_PULSE_ON_MS;
			pulse_off_ms_q  <= RST_PULSE_OFF_MS;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_RUN_SECONDS:   run_seconds_q   <= cfg.data;
				REG_CYCLE_SECONDS: cycle_seconds_q <= cfg.data;
				REG_FREE_SECONDS:  free_seconds_q  <= cfg.data;
				REG_PULSE_ON_MS:   pulse_on_ms_q   <= cfg.data;
				REG_PULSE_OFF_MS:  pulse_off_ms_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (din.ready) begin
			in_valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			second_edge_s1 <= din.second_edge;
			power_on_s1    <= din.power_on;
			level_s1       <= din.level;
		end
	end

	// The phase checks run in order within one tick, so zero run or free
	// times let one tick pass through several phases.
	always_comb begin
		ph_n   = phase_q;
		cnt_n  = count_q;
		pa_n   = pulse_active_q;
		pms_n  = pulse_ms_q;
		feed_n = feed_q;
		rel_n  = release_q;
		ult_n  = ultra_q;

		if (second_edge_s1) begin
			if (power_on_s1) begin
				if (cnt_n != CNT_MAX) begin
					cnt_n = cnt_n + 1'b1;
				end
			end else begin
				ph_n  = PH_START;
				cnt_n = '0;
			end
		end

		if (power_on_s1) begin
			if (ph_n == PH_START) begin
				feed_n = 1'b1;
				ph_n   = PH_RUN;
				cnt_n  = '0;
			end
			if (ph_n == PH_RUN && CMP_BITS'(cnt_n) >= CMP_BITS'(run_seconds_q)) begin
				feed_n = 1'b0;
				ph_n   = PH_PULSE;
				cnt_n  = '0;
				pms_n  = '0;
				pa_n   = 1'b1;
				ult_n  = 1'b1;
			end
			if (ph_n == PH_PULSE) begin
				if (CMP_BITS'(cnt_n) >= CMP_BITS'(cycle_seconds_q)) begin
					rel_n = 1'b1;
					ph_n  = PH_FREE;
					cnt_n = '0;
					ult_n = 1'b0;
				end else if (pa_n) begin
					if (pms_n > pulse_on_ms_q) begin
						pa_n  = 1'b0;
						pms_n = '0;
						ult_n = 1'b0;
					end
				end else begin
					if (pms_n > pulse_off_ms_q) begin
						pa_n  = 1'b1;
						pms_n = '0;
						ult_n = 1'b1;
					end
				end
			end
			if (ph_n == PH_FREE && CMP_BITS'(cnt_n) >= CMP_BITS'(free_seconds_q)) begin
				rel_n = 1'b0;
				ph_n  = PH_START;
				cnt_n = '0;
			end
		end else begin
			feed_n = 1'b0;
			rel_n  = 1'b0;
			ult_n  = 1'b0;
		end

		if (pms_n != PMS_MAX) begin
			pms_n = pms_n + 1'b1;
		end

		cnt_w = CMP_BITS'(cnt_n);

		res_n.relay_feed       = feed_n;
		res_n.relay_release    = rel_n;
		res_n.relay_ultrasonic = ult_n;
		res_n.phase            = ph_n;
		res_n.elapsed_seconds  = (cnt_w > CMP_BITS'({OUT_CNT_BITS{1'b1}})) ?
			{OUT_CNT_BITS{1'b1}} : cnt_w[OUT_CNT_BITS-1:0];
		res_n.pwm_load         = (level_s1 != last_level_q) && (ph_n == PH_PULSE);
		res_n.pwm_compare      = res_n.pwm_load ? level_s1 : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_START;
			count_q        <= '0;
			pulse_active_q <= 1'b0;
			pulse_ms_q     <= '0;
			feed_q         <= 1'b0;
			release_q      <= 1'b0;
			ultra_q        <= 1'b0;
			last_level_q   <= '0;
		end else if (advance) begin
			phase_q        <= ph_n;
			count_q        <= cnt_n;
			pulse_active_q <= pa_n;
			pulse_ms_q     <= pms_n;
			feed_q         <= feed_n;
			release_q      <= rel_n;
			ultra_q        <= ult_n;
			last_level_q   <= level_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_n;
		end
	end

	assign dout.valid            = out_valid_q;
	assign dout.relay_feed       = res_q.relay_feed;
	assign dout.relay_release    = res_q.relay_release;
	assign dout.relay_ultrasonic = res_q.relay_ultrasonic;
	assign dout.phase            = res_q.phase;
	assign dout.elapsed_seconds  = res_q.elapsed_seconds;
	assign dout.pwm_load         = res_q.pwm_load;
	assign dout.pwm_compare      = res_q.pwm_compare;

`ifndef SYNTH
	// Feed and release relays belong to different phases.
	a_relays_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.relay_feed && res_q.relay_release))
		else $error("feed and release relays energized together");

	// The ultrasonic relay only runs in the pulse phase.
	a_ultra_in_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.relay_ultrasonic) |-> (res_q.phase == PH_PULSE))
		else $error("ultrasonic relay on outside pulse phase");

	// A reload is only requested in the pulse phase.
	a_load_in_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.pwm_load) |-> (res_q.phase == PH_PULSE))
		else $error("pwm reload outside pulse phase");

	// A held input tick must not be overwritten or dropped.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && !advance) |=> (in_valid_s1 && $stable(level_s1)))
		else $error("input register lost a pending tick");
`endif

endmodule
